### hw/rtl/fpsd_pkg.sv
// Shared types and constants for the saturating 16.16 fixed-point divider.
// No dependencies; imported by every fpsd_* module.
package fpsd_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned DIV_STEPS = 32;   // quotient bits, one per divide stage

   localparam int unsigned SAT_SHIFT   = 14;
   localparam int unsigned BIG_SHIFT   = 8;
   localparam int unsigned SMALL_SHIFT = 16;

   localparam logic [WORD_W-1:0] BIG_DIVISOR = 32'h0001_0000;
   localparam logic [WORD_W-1:0] MOST_NEG    = 32'h8000_0000;
   localparam logic [WORD_W-1:0] MOST_POS    = 32'h7FFF_FFFF;

   // Magnitudes and result sign after the first front stage.
   typedef struct packed {
      logic [WORD_W-1:0] mag_a;
      logic [WORD_W-1:0] mag_b;
      logic              neg;
   } fpsd_mag_type;

   // Per-item control carried along the divide pipeline.
   typedef struct packed {
      logic sat;
      logic neg;
   } fpsd_ctl_type;

   // Restoring-divide working set: partial remainder, a shift register that
   // holds the unused dividend bits on top and the quotient bits below,
   // the divisor and the control bits.
   typedef struct packed {
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] shreg;
      logic [WORD_W-1:0] den;
      fpsd_ctl_type      ctl;
   } fpsd_work_type;

endpackage

### hw/rtl/fpsd_front.sv
// Front end of the divider: two register stages that take magnitudes, check
// for saturation and scale the operands. Depends on fpsd_pkg.
module fpsd_front
   import fpsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [WORD_W-1:0] dividend,
   input  logic [WORD_W-1:0] divisor,
   output logic              out_valid,
   input  logic              out_ready,
   output fpsd_work_type     out_work
);

   fpsd_mag_type  mag_ff, mag_in;
   logic          mag_valid_ff;
   fpsd_work_type work_ff, work_in;
   logic          work_valid_ff;
   logic          mag_ready, work_ready;
   logic          big;
   logic [2*WORD_W-SMALL_SHIFT-1:0] num;   // 48-bit scaled dividend

   assign work_ready = !work_valid_ff || out_ready;
   assign mag_ready  = !mag_valid_ff || work_ready;
   assign in_ready   = mag_ready;

   // stage 1: magnitudes (|INT_MIN| is 2^31 unsigned)
   always_comb begin
      mag_in.mag_a = dividend[WORD_W-1] ? WORD_W'(0 - dividend) : dividend;
      mag_in.mag_b = divisor[WORD_W-1]  ? WORD_W'(0 - divisor)  : divisor;
      mag_in.neg   = dividend[WORD_W-1] ^ divisor[WORD_W-1];
   end

   // stage 2: saturation test and scaling; result is floor(num / den)
   always_comb begin
      big = mag_ff.mag_b >= BIG_DIVISOR;
      if (big) begin
         num = {16'b0, mag_ff.mag_a} << BIG_SHIFT;
         work_in.den = mag_ff.mag_b >> BIG_SHIFT;
      end else begin
         num = {16'b0, mag_ff.mag_a} << SMALL_SHIFT;
         work_in.den = mag_ff.mag_b;
      end
      work_in.rem     = {16'b0, num[2*WORD_W-SMALL_SHIFT-1:WORD_W]};
      work_in.shreg   = num[WORD_W-1:0];
      work_in.ctl.sat = (mag_ff.mag_a >> SAT_SHIFT) >= mag_ff.mag_b;
      work_in.ctl.neg = mag_ff.neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff  <= 1'b0;
         work_valid_ff <= 1'b0;
      end else begin
         if (mag_ready) begin
            mag_valid_ff <= in_valid;
         end
         if (work_ready) begin
            work_valid_ff <= mag_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && mag_ready) begin
         mag_ff <= mag_in;
      end
      if (mag_valid_ff && work_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = work_valid_ff;
   assign out_work  = work_ff;

endmodule

### hw/rtl/fpsd_div_stage.sv
// One restoring-division step: one quotient bit per register stage.
// Depends on fpsd_pkg.
module fpsd_div_stage
   import fpsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  fpsd_work_type in_work,
   output logic          out_valid,
   input  logic          out_ready,
   output fpsd_work_type out_work
);

   fpsd_work_type work_ff, work_in;
   logic          valid_ff;
   logic [WORD_W:0] trial, diff;
   logic          take;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      trial = {in_work.rem, in_work.shreg[WORD_W-1]};
      diff  = trial - {1'b0, in_work.den};
      take  = !diff[WORD_W];
      work_in       = in_work;
      work_in.rem   = take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      work_in.shreg = {in_work.shreg[WORD_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

### hw/rtl/fpsd_back.sv
// Output stage: applies saturation and sign, and holds the response register.
// Depends on fpsd_pkg.
module fpsd_back
   import fpsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpsd_work_type     in_work,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [WORD_W-1:0] quotient
);

   logic [WORD_W-1:0] quotient_ff, quotient_in;
   logic              valid_ff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (in_work.ctl.sat) begin
         quotient_in = in_work.ctl.neg ? MOST_NEG : MOST_POS;
      end else if (in_work.ctl.neg) begin
         quotient_in = WORD_W'(0 - in_work.shreg);
      end else begin
         quotient_in = in_work.shreg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         quotient_ff <= quotient_in;
      end
   end

   assign out_valid = valid_ff;
   assign quotient  = quotient_ff;

endmodule

### hw/rtl/fixed_point_saturating_divide_unit.sv
// Channel   | Ports                          | Payload (low bits first)
// ----------+--------------------------------+------------------------------------
// request   | req_tvalid/req_tready/req_tdata | dividend[31:0], divisor[63:32]
// response  | rsp_tvalid/rsp_tready/rsp_tdata | quotient[31:0]
//
// Pipeline: two front stages, 32 divide stages (one restoring step each),
// one output register. Throughput is one request per cycle when not stalled.
// Every stage has its own valid bit and ready; a stalled response only holds
// stages that are full, so empty slots close up and nothing is dropped.
// Synchronous active-high reset clears the valid bits only.
//
// Top level of the saturating signed 16.16 fixed-point divider.
// Depends on fpsd_pkg, fpsd_front, fpsd_div_stage, fpsd_back.
module fixed_point_saturating_divide_unit
   import fpsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,    // dividend[31:0], divisor[63:32]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata     // quotient[31:0]
);

   // pipeline links: index 0 is the front output, index DIV_STEPS the last step
   fpsd_work_type link_work  [DIV_STEPS+1];
   logic          link_valid [DIV_STEPS+1];
   logic          link_ready [DIV_STEPS+1];

   // Magnitudes, saturation test (|a|>>14 >= |b|, covers a zero divisor)
   // and operand scaling for the large / small divisor cases.
   fpsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .dividend  (req_tdata[WORD_W-1:0]),
      .divisor   (req_tdata[2*WORD_W-1:WORD_W]),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_work  (link_work[0])
   );

   // Unsigned restoring division, one quotient bit per stage, MSB first.
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
      fpsd_div_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_work   (link_work[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_work  (link_work[i+1])
      );
   end

   // Saturation / sign fix-up and the response register.
   fpsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[DIV_STEPS]),
      .in_ready  (link_ready[DIV_STEPS]),
      .in_work   (link_work[DIV_STEPS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .quotient  (rsp_tdata)
   );

endmodule
